FILE: rtl/pair_proximity_accumulator_top_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef PAIR_PROXIMITY_ACCUMULATOR_TOP_MACROS_SVH
`define PAIR_PROXIMITY_ACCUMULATOR_TOP_MACROS_SVH

// Overlapping implication, disabled while reset is held.
`define PPA_ASSERT_NOW(label, clock, rstn, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, checked during reset as well.
`define PPA_ASSERT_NEXT(label, clock, ante, cons, msg) \
  label: assert property (@(posedge clock) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ppa_pkg.sv
package ppa_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int TABLE_DEPTH_DEF = 256;

  localparam int ID_W    = 32;
  localparam int POS_W   = 16;
  localparam int IDX_W   = 8;
  localparam int WGT_W   = 32;
  localparam int USED_W  = 9;
  localparam int DEN_W   = POS_W + 1;
  localparam int NUM_W   = 9;
  localparam logic [NUM_W-1:0] DIV_NUM = 9'd256;
  localparam logic [DEN_W-1:0] DIST_OFS = 17'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_VALID     = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_DONE_DROP = 2'd3;

  typedef struct packed {
    logic              operation;
    logic [ID_W-1:0]   entity_id;
    logic [POS_W-1:0]  position;
    logic              last_point;
    logic [IDX_W-1:0]  entry_index;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]   entity_a;
    logic [ID_W-1:0]   entity_b;
    logic [WGT_W-1:0]  weight;
    logic [1:0]        status;
    logic [USED_W-1:0] entries_used;
  } out_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_res_t;

endpackage

FILE: rtl/ppa_div.sv
module ppa_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ppa_pkg::DEN_W-1:0] den,
  output ppa_pkg::div_res_t         res
);
  import ppa_pkg::*;

  // Restoring division of the fixed numerator, one quotient bit per cycle.
  logic               busy_r, busy_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [DEN_W:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]   den_r;
  logic [NUM_W-1:0]   q_r, q_nxt;
  logic               done_r, done_nxt;
  logic [DEN_W:0]     shifted;

  always_comb begin
    busy_nxt = busy_r;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[DEN_W-1:0], DIV_NUM[bit_r]};
    if (start) begin
      busy_nxt = 1'b1;
      bit_nxt  = 4'(NUM_W - 1);
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt       = shifted - {1'b0, den_r};
        q_nxt[bit_r]  = 1'b1;
      end else begin
        rem_nxt = shifted;
      end
      if (bit_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        bit_nxt = bit_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign res.done = done_r;
  assign res.quot = q_r;

endmodule

FILE: rtl/pair_proximity_accumulator_top.sv
// Pair proximity accumulator.
// Input beats on in_valid/in_stall carry either a point load or a table read.
// Points are buffered until the beat marked last; the block then walks every
// pair of buffered points once and adds 256/(|distance|+2) into a table
// keyed by the unordered pair of entity ids, appending new keys in order.
// The group end gives one result beat with status done (or done with drops);
// a read beat gives one result beat with the slot contents or status empty.
// A load beat without the last mark gives no result.
// A read fetches the slot and then gives its result. A group end, for each
// pair of points, fetches the two points, skips the pair if their ids are
// equal, else runs the bit-serial divider, then searches the table slot by
// slot (single read port), adds to a match or appends a new key, and steps on.
// While a beat is being worked on, in_stall is high. A finished result sits
// in the output register; if out_stall holds it there, in_stall stays high
// until it has gone. Reset (synchronous, rst_n low) empties the point buffer
// and the table by clearing their counts; no clearing pass is needed.
module pair_proximity_accumulator_top #(
  parameter int MAX_POINTS  = ppa_pkg::MAX_POINTS_DEF,
  parameter int TABLE_DEPTH = ppa_pkg::TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ppa_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ppa_pkg::out_t out_data
);
  import ppa_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PW = $clog2(MAX_POINTS + 1) + 1;
  localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (SW > IDX_W) ? SW : IDX_W;
  localparam int EW = (SW > USED_W) ? SW : USED_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_RDB  = 4'd2;
  localparam logic [3:0] S_PRD  = 4'd3;
  localparam logic [3:0] S_PCHK = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_SRD  = 4'd6;
  localparam logic [3:0] S_SCMP = 4'd7;
  localparam logic [3:0] S_ADV  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  // Point buffer and pair table; contents are only meaningful below the counts.
  logic [ID_W-1:0]  pt_id  [MAX_POINTS];
  logic [POS_W-1:0] pt_pos [MAX_POINTS];
  logic [ID_W-1:0]  tb_a   [TABLE_DEPTH];
  logic [ID_W-1:0]  tb_b   [TABLE_DEPTH];
  logic [WGT_W-1:0] tb_w   [TABLE_DEPTH];

  logic [3:0]       state_r, state_nxt;
  logic [PW-1:0]    cnt_r, cnt_nxt;
  logic [PW-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic [SW-1:0]    s_r, s_nxt, slots_r, slots_nxt;
  logic             drop_r, drop_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [WGT_W-1:0] wgt_r, wgt_nxt;

  logic [ID_W-1:0]  id_x_r, id_y_r;
  logic [POS_W-1:0] pos_x_r, pos_y_r;
  logic [ID_W-1:0]  rd_a_r, rd_b_r;
  logic [WGT_W-1:0] rd_w_r;

  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic             accept, pt_we;
  logic             tb_we;
  logic [TW-1:0]    tb_waddr, tb_raddr;
  logic [ID_W-1:0]  tb_wa, tb_wb;
  logic [WGT_W-1:0] tb_ww;

  logic             div_start;
  logic [DEN_W-1:0] div_den;
  div_res_t         div_res;
  logic [POS_W-1:0] pos_gap;
  logic             pair_hit;
  logic [WGT_W:0]   sum;
  logic [XW-1:0]    idx_ext, slots_ext;
  logic [EW-1:0]    used_ext;

  ppa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .den   (div_den),
    .res   (div_res)
  );

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign idx_ext   = XW'(idx_r);
  assign slots_ext = XW'(slots_r);
  assign used_ext  = EW'(slots_r);
  assign tb_raddr  = (state_r == S_RDA) ? idx_ext[TW-1:0] : s_r[TW-1:0];

  assign pos_gap  = (pos_y_r >= pos_x_r) ? (pos_y_r - pos_x_r) : (pos_x_r - pos_y_r);
  assign div_den  = {1'b0, pos_gap} + DIST_OFS;
  assign pair_hit = (rd_a_r == id_x_r && rd_b_r == id_y_r) ||
                    (rd_a_r == id_y_r && rd_b_r == id_x_r);
  assign sum      = {1'b0, rd_w_r} + {1'b0, wgt_r};
  assign pt_we    = accept && (in_data.operation == OP_LOAD) &&
                    (cnt_r < PW'(MAX_POINTS));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    s_nxt         = s_r;
    slots_nxt     = slots_r;
    drop_nxt      = drop_r;
    idx_nxt       = idx_r;
    wgt_nxt       = wgt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    tb_we         = 1'b0;
    tb_waddr      = s_r[TW-1:0];
    tb_wa         = id_x_r;
    tb_wb         = id_y_r;
    tb_ww         = wgt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.operation == OP_READ) begin
            idx_nxt   = in_data.entry_index;
            state_nxt = S_RDA;
          end else begin
            if (pt_we) begin
              cnt_nxt = cnt_r + PW'(1);
            end else begin
              drop_nxt = 1'b1;
            end
            if (in_data.last_point) begin
              x_nxt     = '0;
              y_nxt     = PW'(1);
              state_nxt = (cnt_nxt < PW'(2)) ? S_FIN : S_PRD;
            end
          end
        end
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.entries_used = used_ext[USED_W-1:0];
        if (idx_ext < slots_ext) begin
          out_data_nxt.entity_a = rd_a_r;
          out_data_nxt.entity_b = rd_b_r;
          out_data_nxt.weight   = rd_w_r;
          out_data_nxt.status   = ST_VALID;
        end else begin
          out_data_nxt.entity_a = '0;
          out_data_nxt.entity_b = '0;
          out_data_nxt.weight   = '0;
          out_data_nxt.status   = ST_EMPTY;
        end
        state_nxt = S_IDLE;
      end
      S_PRD: state_nxt = S_PCHK;
      S_PCHK: begin
        if (id_x_r == id_y_r) begin
          state_nxt = S_ADV;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          wgt_nxt   = WGT_W'(div_res.quot);
          s_nxt     = '0;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (s_r >= slots_r) begin
          // Key not present: append it if there is room.
          if (slots_r < SW'(TABLE_DEPTH)) begin
            tb_we     = 1'b1;
            tb_waddr  = slots_r[TW-1:0];
            slots_nxt = slots_r + SW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          state_nxt = S_ADV;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (pair_hit) begin
          tb_we     = 1'b1;
          tb_wa     = rd_a_r;
          tb_wb     = rd_b_r;
          tb_ww     = sum[WGT_W] ? '1 : sum[WGT_W-1:0];
          state_nxt = S_ADV;
        end else begin
          s_nxt     = s_r + SW'(1);
          state_nxt = S_SRD;
        end
      end
      S_ADV: begin
        if (y_r + PW'(1) < cnt_r) begin
          y_nxt     = y_r + PW'(1);
          state_nxt = S_PRD;
        end else if (x_r + PW'(2) < cnt_r) begin
          x_nxt     = x_r + PW'(1);
          y_nxt     = x_r + PW'(2);
          state_nxt = S_PRD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.entity_a     = '0;
        out_data_nxt.entity_b     = '0;
        out_data_nxt.weight       = '0;
        out_data_nxt.status       = drop_r ? ST_DONE_DROP : ST_DONE;
        out_data_nxt.entries_used = used_ext[USED_W-1:0];
        cnt_nxt                   = '0;
        drop_nxt                  = 1'b0;
        state_nxt                 = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      slots_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      slots_r     <= slots_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    s_r        <= s_nxt;
    idx_r      <= idx_nxt;
    wgt_r      <= wgt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Point buffer: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_id[cnt_r[AW-1:0]]  <= in_data.entity_id;
      pt_pos[cnt_r[AW-1:0]] <= in_data.position;
    end
    id_x_r  <= pt_id[x_r[AW-1:0]];
    pos_x_r <= pt_pos[x_r[AW-1:0]];
    id_y_r  <= pt_id[y_r[AW-1:0]];
    pos_y_r <= pt_pos[y_r[AW-1:0]];
  end

  // Pair table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (tb_we) begin
      tb_a[tb_waddr] <= tb_wa;
      tb_b[tb_waddr] <= tb_wb;
      tb_w[tb_waddr] <= tb_ww;
    end
    rd_a_r <= tb_a[tb_raddr];
    rd_b_r <= tb_b[tb_raddr];
    rd_w_r <= tb_w[tb_raddr];
  end

endmodule

FILE: rtl/ppa_checker.sv
`include "pair_proximity_accumulator_top_macros.svh"

module ppa_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input ppa_pkg::out_t out_data
);
  import ppa_pkg::*;

  `PPA_ASSERT_NEXT(a_reset_idle, clk, !rst_n, !out_valid, "result beat straight after reset")
  `PPA_ASSERT_NOW(a_hold_blocks_input, clk, rst_n, out_valid && out_stall, in_stall, "input taken while a result waits")
  `PPA_ASSERT_NOW(a_empty_is_zero, clk, rst_n, out_valid && out_data.status == ST_EMPTY, out_data.weight == '0 && out_data.entity_a == '0 && out_data.entity_b == '0, "empty slot with payload")
  `PPA_ASSERT_NOW(a_valid_has_entries, clk, rst_n, out_valid && out_data.status == ST_VALID, out_data.entries_used != '0, "valid slot but table empty")

endmodule

bind pair_proximity_accumulator_top ppa_checker u_ppa_checker (.*);
